// File: hdl/alc_pkg.sv
package alc_pkg;

	localparam int CNT_W   = 16;
	localparam int SCALE_W = 19;
	localparam int CH_W    = 22;
	localparam int COEF_W  = 10;
	localparam int PROD_W  = CH_W + COEF_W;
	localparam int LUX_W   = 17;
	localparam int NSEG    = 8;
	localparam int IDX_W   = 3;

	localparam int CH_SHIFT    = 10;
	localparam int RATIO_SHIFT = 9;
	localparam int LUX_SHIFT   = 14;

	localparam logic [LUX_W-1:0] SAT_LUX = 17'h10000;

	typedef logic [CH_W-1:0]    ch_t;
	typedef logic [COEF_W-1:0]  coef_t;
	typedef logic [SCALE_W-1:0] scale_t;

	// one scaled reading pair travelling through the queue
	typedef struct packed {
		logic clipped;
		ch_t  ch0;
		ch_t  ch1;
	} alc_item_t;

	function automatic logic [CNT_W-1:0] clip_level(input logic [1:0] itime);
		logic [CNT_W-1:0] lvl;
		case (itime)
			2'd0:    lvl = 16'd4900;
			2'd1:    lvl = 16'd37000;
			default: lvl = 16'd65000;
		endcase
		return lvl;
	endfunction

	function automatic logic [14:0] scale_base(input logic [1:0] itime);
		logic [14:0] s;
		case (itime)
			2'd0:    s = 15'h7517;
			2'd1:    s = 15'h0FE7;
			default: s = 15'h0400;
		endcase
		return s;
	endfunction

	function automatic coef_t seg_k(input logic cs, input logic [IDX_W-1:0] i);
		coef_t v;
		case ({cs, i})
			4'd0:    v = 10'h040;
			4'd1:    v = 10'h080;
			4'd2:    v = 10'h0c0;
			4'd3:    v = 10'h100;
			4'd4:    v = 10'h138;
			4'd5:    v = 10'h19a;
			4'd8:    v = 10'h043;
			4'd9:    v = 10'h085;
			4'd10:   v = 10'h0c8;
			4'd11:   v = 10'h10a;
			4'd12:   v = 10'h14d;
			4'd13:   v = 10'h19a;
			default: v = 10'h29a;
		endcase
		return v;
	endfunction

	function automatic coef_t seg_b(input logic cs, input logic [IDX_W-1:0] i);
		coef_t v;
		case ({cs, i})
			4'd0:    v = 10'h1f2;
			4'd1:    v = 10'h214;
			4'd2:    v = 10'h23f;
			4'd3:    v = 10'h270;
			4'd4:    v = 10'h16f;
			4'd5:    v = 10'h0d2;
			4'd6:    v = 10'h018;
			4'd8:    v = 10'h204;
			4'd9:    v = 10'h228;
			4'd10:   v = 10'h253;
			4'd11:   v = 10'h282;
			4'd12:   v = 10'h177;
			4'd13:   v = 10'h101;
			4'd14:   v = 10'h037;
			default: v = 10'h000;
		endcase
		return v;
	endfunction

	function automatic coef_t seg_m(input logic cs, input logic [IDX_W-1:0] i);
		coef_t v;
		case ({cs, i})
			4'd0:    v = 10'h1be;
			4'd1:    v = 10'h2d1;
			4'd2:    v = 10'h37b;
			4'd3:    v = 10'h3fe;
			4'd4:    v = 10'h1fc;
			4'd5:    v = 10'h0fb;
			4'd6:    v = 10'h012;
			4'd8:    v = 10'h1ad;
			4'd9:    v = 10'h2c1;
			4'd10:   v = 10'h363;
			4'd11:   v = 10'h3df;
			4'd12:   v = 10'h1dd;
			4'd13:   v = 10'h127;
			4'd14:   v = 10'h02b;
			default: v = 10'h000;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/alc_front.sv
module alc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [15:0]             broadband_count,
	input  logic [15:0]             infrared_count,
	input  logic [1:0]              integration_time,
	input  logic                    gain_high,
	input  logic                    q_full,
	output logic                    q_push,
	output alc_pkg::alc_item_t      q_item
);
	import alc_pkg::*;

	logic              vld_s1;
	alc_item_t         item_s1;
	logic              load;
	logic [CNT_W-1:0]  clip_lvl;
	scale_t            scale;
	logic [34:0]       prod0;
	logic [34:0]       prod1;
	alc_item_t         item_d;

	always_comb begin
		clip_lvl = clip_level(integration_time);
		scale    = gain_high ? SCALE_W'(scale_base(integration_time))
		                     : SCALE_W'(scale_base(integration_time)) << 4;
		prod0    = 35'(broadband_count) * 35'(scale);
		prod1    = 35'(infrared_count) * 35'(scale);
		item_d.clipped = (broadband_count > clip_lvl) || (infrared_count > clip_lvl);
		item_d.ch0     = prod0[CH_SHIFT +: CH_W];
		item_d.ch1     = prod1[CH_SHIFT +: CH_W];
	end

	assign q_push   = vld_s1 && !q_full;
	assign load     = !vld_s1 || !q_full;
	assign in_stall = !load;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: hdl/alc_queue.sv
module alc_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  alc_pkg::alc_item_t  push_item,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output alc_pkg::alc_item_t  head_item
);
	import alc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_Q = $clog2(DEPTH + 1);

	alc_item_t          mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_Q-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CNT_Q'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_item = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: hdl/alc_back.sv
module alc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                package_cs,
	input  logic                q_empty,
	input  alc_pkg::alc_item_t  q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [16:0]         lux,
	output logic                clipped
);
	import alc_pkg::*;

	typedef struct packed {
		logic             clipped;
		logic             found;
		logic [IDX_W-1:0] idx;
		ch_t              ch0;
		ch_t              ch1;
	} srch_t;

	localparam int NSTG = NSEG - 1;

	srch_t               srch_q [NSTG + 1];
	srch_t               srch_d [NSTG];
	logic [NSTG:0]       srch_vld_q;
	logic                adv;

	logic                prd_vld_q;
	logic                prd_clip_q;
	logic [PROD_W-1:0]   p0_q;
	logic [PROD_W-1:0]   p1_q;
	logic                dif_vld_q;
	logic                dif_clip_q;
	logic [PROD_W-1:0]   diff_q;
	logic                out_vld_q;
	logic [LUX_W-1:0]    lux_q;
	logic                clip_q;
	logic [PROD_W:0]     rounded;

	// whole back end moves together whenever the output register can take a value
	assign adv   = !out_vld_q || !out_stall;
	assign q_pop = adv && !q_empty;

	// one breakpoint per stage: ratio <= k  <=>  (ch1 << 10) < (2k+1) * ch0
	for (genvar j = 0; j < NSTG; j++) begin : g_srch
		logic [COEF_W:0]   odd_k;
		logic [PROD_W:0]   rhs;
		logic [PROD_W-1:0] lhs;
		logic              hit;

		always_comb begin
			odd_k  = {seg_k(package_cs, IDX_W'(j)), 1'b1};
			lhs    = {srch_q[j].ch1, (RATIO_SHIFT + 1)'(0)};
			rhs    = (PROD_W + 1)'(srch_q[j].ch0) * (PROD_W + 1)'(odd_k);
			hit    = (srch_q[j].ch0 == '0) || ({1'b0, lhs} < rhs);
			srch_d[j] = srch_q[j];
			if (!srch_q[j].found && hit) begin
				srch_d[j].found = 1'b1;
				srch_d[j].idx   = IDX_W'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_vld_q <= '0;
			prd_vld_q  <= 1'b0;
			dif_vld_q  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else if (adv) begin
			srch_vld_q <= {srch_vld_q[NSTG-1:0], !q_empty};
			prd_vld_q  <= srch_vld_q[NSTG];
			dif_vld_q  <= prd_vld_q;
			out_vld_q  <= dif_vld_q;
		end
	end

	assign rounded = {1'b0, diff_q} + (PROD_W + 1)'(1 << (LUX_SHIFT - 1));

	always_ff @(posedge clk) begin
		if (adv) begin
			srch_q[0].clipped <= q_item.clipped;
			srch_q[0].found   <= 1'b0;
			srch_q[0].idx     <= IDX_W'(NSEG - 1);
			srch_q[0].ch0     <= q_item.ch0;
			srch_q[0].ch1     <= q_item.ch1;
			for (int s = 0; s < NSTG; s++) begin
				srch_q[s+1] <= srch_d[s];
			end
			prd_clip_q <= srch_q[NSTG].clipped;
			p0_q <= PROD_W'(srch_q[NSTG].ch0) *
			        PROD_W'(seg_b(package_cs, srch_q[NSTG].idx));
			p1_q <= PROD_W'(srch_q[NSTG].ch1) *
			        PROD_W'(seg_m(package_cs, srch_q[NSTG].idx));
			dif_clip_q <= prd_clip_q;
			diff_q     <= (p0_q > p1_q) ? p0_q - p1_q : '0;
			clip_q     <= dif_clip_q;
			lux_q      <= dif_clip_q ? SAT_LUX : rounded[LUX_SHIFT +: LUX_W];
		end
	end

	assign out_valid = out_vld_q;
	assign lux       = lux_q;
	assign clipped   = clip_q;

endmodule

// File: hdl/ambient_light_lux_calc.sv
// channel   direction  handshake           payload
// in        sink       in_valid/in_stall   broadband_count[15:0], infrared_count[15:0]
// out       source     out_valid/out_stall lux[16:0], clipped
// config    sink       apb (psel/penable)  integration_time @0x0, gain_high @0x4,
//                                          package_cs @0x8
//
// one transaction per clock in and out while nothing stalls; the breakpoint search is
// pipelined, one breakpoint compare per stage, so the datapath never iterates on an item
// a result passes through the front register, queue, 8 search stages, product,
// difference and output register
// arst_n clears valids, queue pointers and the config registers (all zero)
// an output stall freezes the back end; the queue soaks up what the front has
// in flight, and in_stall rises only once the queue is full
module ambient_light_lux_calc #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input transaction
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] broadband_count,
	input  logic [15:0] infrared_count,
	// result transaction
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] lux,
	output logic        clipped,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import alc_pkg::*;

	localparam logic [1:0] REG_ITIME = 2'd0;
	localparam logic [1:0] REG_GAIN  = 2'd1;
	localparam logic [1:0] REG_PKG   = 2'd2;

	logic [1:0]  itime_q;
	logic        gain_q;
	logic        pkg_cs_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	alc_item_t   push_item;
	alc_item_t   head_item;

	// register file: written on the access phase, always ready
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itime_q  <= '0;
			gain_q   <= 1'b0;
			pkg_cs_q <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ITIME: itime_q  <= pwdata[1:0];
				REG_GAIN:  gain_q   <= pwdata[0];
				REG_PKG:   pkg_cs_q <= pwdata[0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ITIME: prdata = {30'd0, itime_q};
			REG_GAIN:  prdata = {31'd0, gain_q};
			REG_PKG:   prdata = {31'd0, pkg_cs_q};
			default:   prdata = '0;
		endcase
	end

	// front: clip check and integration/gain scaling
	alc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.broadband_count  (broadband_count),
		.infrared_count   (infrared_count),
		.integration_time (itime_q),
		.gain_high        (gain_q),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_item           (push_item)
	);

	// decoupling queue between the two halves
	alc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head_item (head_item)
	);

	// back: breakpoint search, coefficient products, clamp and rounding
	alc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.package_cs (pkg_cs_q),
		.q_empty    (q_empty),
		.q_item     (head_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.lux        (lux),
		.clipped    (clipped)
	);

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

	// register map of the configuration port
	localparam logic [3:0] REG_ITIME = 4'h0;
	localparam logic [3:0] REG_GAIN  = 4'h4;
	localparam logic [3:0] REG_PKG   = 4'h8;
	localparam logic [3:0] REG_SPARE = 4'hC;  // past the last register, must be ignored

	localparam logic [16:0] SATURATED   = 17'h10000;
	localparam int          STUCK_LIMIT = 2000;  // cycles with no transaction on either side
	localparam int          DRAIN_WAIT  = 20;    // settle time after the last result
	localparam int          PHASES      = 16;
	localparam int          PER_PHASE   = 84;
	localparam int          HOLD_CYCLES = 120;   // long output stall to back up the queue

	typedef struct packed {
		logic [16:0] lux;
		logic        clipped;
	} lux_rd_t;

	// one directed reading; settings are applied before it when they differ
	typedef struct packed {
		logic [1:0]  itime;
		logic        gain;
		logic        cs;
		logic [15:0] bb;
		logic [15:0] ir;
		logic        typed;  // expectation given in the row rather than predicted
		logic [16:0] lux;
		logic        clip;
	} probe_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] broadband_count = '0;
	logic [15:0] infrared_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [16:0] lux;
	logic        clipped;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// breakpoint tables, [package][segment]: ratio knee, ch0 and ch1 coefficients
	int unsigned seg_knee [2][8] = '{
		'{16'h040, 16'h080, 16'h0c0, 16'h100, 16'h138, 16'h19a, 16'h29a, 16'h29a},
		'{16'h043, 16'h085, 16'h0c8, 16'h10a, 16'h14d, 16'h19a, 16'h29a, 16'h29a}};
	int unsigned seg_b [2][8] = '{
		'{16'h1f2, 16'h214, 16'h23f, 16'h270, 16'h16f, 16'h0d2, 16'h018, 16'h000},
		'{16'h204, 16'h228, 16'h253, 16'h282, 16'h177, 16'h101, 16'h037, 16'h000}};
	int unsigned seg_m [2][8] = '{
		'{16'h1be, 16'h2d1, 16'h37b, 16'h3fe, 16'h1fc, 16'h0fb, 16'h012, 16'h000},
		'{16'h1ad, 16'h2c1, 16'h363, 16'h3df, 16'h1dd, 16'h127, 16'h02b, 16'h000}};

	// directed readings: clip edges of every integration time, zero broadband,
	// ratio past the last knee, both packages, both gains, the spare time code
	probe_t probes [21] = '{
		'{2'd0, 1'b0, 1'b0, 16'd0,     16'd0,     1'b1, 17'd0,     1'b0},  // after reset
		'{2'd0, 1'b0, 1'b0, 16'd4900,  16'd0,     1'b0, 17'd0,     1'b0},  // largest lux
		'{2'd0, 1'b0, 1'b0, 16'd4901,  16'd0,     1'b1, SATURATED, 1'b1},
		'{2'd0, 1'b0, 1'b0, 16'd0,     16'd4901,  1'b1, SATURATED, 1'b1},
		'{2'd0, 1'b0, 1'b0, 16'd65535, 16'd65535, 1'b1, SATURATED, 1'b1},
		'{2'd0, 1'b0, 1'b0, 16'd0,     16'd1000,  1'b1, 17'd0,     1'b0},  // negative, clamped
		'{2'd0, 1'b0, 1'b0, 16'd1000,  16'd2000,  1'b1, 17'd0,     1'b0},  // past last knee
		'{2'd0, 1'b0, 1'b0, 16'd1000,  16'd100,   1'b0, 17'd0,     1'b0},
		'{2'd0, 1'b1, 1'b0, 16'd4900,  16'd600,   1'b0, 17'd0,     1'b0},
		'{2'd0, 1'b1, 1'b1, 16'd3000,  16'd500,   1'b0, 17'd0,     1'b0},
		'{2'd1, 1'b0, 1'b1, 16'd37000, 16'd0,     1'b0, 17'd0,     1'b0},
		'{2'd1, 1'b0, 1'b1, 16'd37001, 16'd5,     1'b1, SATURATED, 1'b1},
		'{2'd1, 1'b1, 1'b1, 16'd20000, 16'd9000,  1'b0, 17'd0,     1'b0},
		'{2'd1, 1'b1, 1'b0, 16'd0,     16'd37001, 1'b1, SATURATED, 1'b1},
		'{2'd2, 1'b1, 1'b0, 16'd65000, 16'd65000, 1'b0, 17'd0,     1'b0},
		'{2'd2, 1'b1, 1'b0, 16'd30000, 16'd65000, 1'b1, 17'd0,     1'b0},
		'{2'd2, 1'b0, 1'b0, 16'd65001, 16'd0,     1'b1, SATURATED, 1'b1},
		'{2'd3, 1'b0, 1'b1, 16'd65000, 16'd65000, 1'b0, 17'd0,     1'b0},
		'{2'd3, 1'b0, 1'b1, 16'd0,     16'd65001, 1'b1, SATURATED, 1'b1},
		'{2'd3, 1'b1, 1'b1, 16'd65535, 16'd0,     1'b1, SATURATED, 1'b1},
		'{2'd3, 1'b1, 1'b1, 16'd1,     16'd0,     1'b0, 17'd0,     1'b0}};

	// bench copy of the register contents
	logic [1:0] cfg_itime = 2'd0;
	logic       cfg_gain = 1'b0;
	logic       cfg_cs = 1'b0;

	lux_rd_t     lux_due [$];  // expected results, oldest first
	bit          rush = 1'b0;  // no gaps and no stalls on either side
	int          hold_req = 0; // long stall requested of the result side
	int          errors = 0;
	int unsigned readings_sent = 0;
	int unsigned results_checked = 0;
	int unsigned saturated_seen = 0;
	int unsigned settings_used = 0;
	int unsigned quiet_cycles = 0;

	ambient_light_lux_calc dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.broadband_count (broadband_count),
		.infrared_count  (infrared_count),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.lux             (lux),
		.clipped         (clipped),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned clip_of(input logic [1:0] itime);
		case (itime)
			2'd0:    return 4900;
			2'd1:    return 37000;
			default: return 65000;  // the spare code behaves as the longest time
		endcase
	endfunction

	// lux for one reading pair under the current bench settings
	function automatic lux_rd_t predict_lux(input logic [15:0] bb, input logic [15:0] ir);
		longint unsigned scl, ch0, ch1, ratio, rounded;
		longint          diff;
		int              idx;
		lux_rd_t         r;
		if (bb > clip_of(cfg_itime) || ir > clip_of(cfg_itime)) begin
			r.lux = SATURATED;
			r.clipped = 1'b1;
			return r;
		end
		case (cfg_itime)
			2'd0:    scl = 64'h7517;
			2'd1:    scl = 64'h0FE7;
			default: scl = 64'd1024;
		endcase
		if (!cfg_gain) scl = scl << 4;  // low gain reads sixteen times lower
		ch0 = (bb * scl) >> 10;
		ch1 = (ir * scl) >> 10;
		// rounded ir/broadband ratio in units of 1/512, zero when broadband is dark
		ratio = (ch0 != 0) ? ((ch1 << 10) / ch0) : 64'd0;
		ratio = (ratio + 1) >> 1;
		idx = 0;
		while (idx < 7 && ratio > seg_knee[cfg_cs][idx]) idx++;
		diff = longint'(ch0 * seg_b[cfg_cs][idx]) - longint'(ch1 * seg_m[cfg_cs][idx]);
		if (diff < 0) diff = 0;
		rounded = (longint'(diff) + 8192) >> 14;
		r.lux = rounded[16:0];
		r.clipped = 1'b0;
		return r;
	endfunction

	// one register transaction: setup then access, finishing on the accepting edge
	task automatic apb_access(input bit wr, input logic [3:0] addr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// write all three registers, optionally with junk in the unused bits, and read back
	task automatic load_settings(input logic [1:0] itime, input logic gain, input logic cs,
		input bit junk);
		logic [31:0] hi, rd;
		logic [31:0] want [3];
		logic [31:0] mask [3];
		logic [3:0]  addr [3];
		want = '{{30'd0, itime}, {31'd0, gain}, {31'd0, cs}};
		mask = '{32'h3, 32'h1, 32'h1};
		addr = '{REG_ITIME, REG_GAIN, REG_PKG};
		hi = junk ? $urandom : 32'd0;
		for (int i = 0; i < 3; i++)
			apb_access(1'b1, addr[i], (hi & ~mask[i]) | want[i], rd);
		cfg_itime = itime;
		cfg_gain = gain;
		cfg_cs = cs;
		for (int i = 0; i < 3; i++) begin
			apb_access(1'b0, addr[i], 32'd0, rd);
			if (rd !== want[i]) begin
				$error("register @%0h readback: expected %0h, got %0h", addr[i], want[i], rd);
				errors++;
			end
		end
		settings_used++;
	endtask

	// offer one reading pair and hold it until the block takes it
	task automatic offer_reading(input logic [15:0] bb, input logic [15:0] ir,
		input bit typed, input lux_rd_t given);
		int gap;
		gap = rush ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		broadband_count <= bb;
		infrared_count <= ir;
		do @(posedge clk); while (in_stall);
		lux_due.push_back(typed ? given : predict_lux(bb, ir));
		readings_sent++;
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (lux_due.size() != 0) @(posedge clk);
	endtask

	// stimulus: directed table, then random phases over all register settings
	initial begin : stimulus
		logic [31:0]  rd;
		logic [15:0]  bb, ir, hot;
		int unsigned  lvl, kind, frac;
		probe_t       p;
		lux_rd_t      given;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// a write past the register map must leave everything at its reset value
		apb_access(1'b1, REG_SPARE, $urandom, rd);

		foreach (probes[i]) begin
			p = probes[i];
			if (p.itime != cfg_itime || p.gain != cfg_gain || p.cs != cfg_cs) begin
				drain_results();
				load_settings(p.itime, p.gain, p.cs, 1'b0);
			end
			given.lux = p.lux;
			given.clipped = p.clip;
			offer_reading(p.bb, p.ir, p.typed, given);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			load_settings(ph[1:0], ph[2], ph[3], ph[0] ^ ph[3]);
			rush = (ph % 4 == 2);
			// one back-to-back phase also gets a long output stall to fill the queue
			if (ph == 6) hold_req = HOLD_CYCLES;
			lvl = clip_of(cfg_itime);
			repeat (PER_PHASE) begin
				kind = $urandom_range(0, 99);
				if (kind < 8) begin
					// one channel over the clip level, the other anything
					hot = 16'($urandom_range(lvl + 1, 65535));
					if ($urandom_range(0, 1)) begin
						bb = hot;
						ir = 16'($urandom);
					end else begin
						bb = 16'($urandom);
						ir = hot;
					end
				end else if (kind < 13) begin
					bb = 16'($urandom);
					ir = 16'($urandom);
				end else if (kind < 16) begin
					bb = 16'd0;
					ir = 16'($urandom_range(0, lvl));
				end else begin
					// in range, ir a random fraction of broadband to sweep every segment
					bb = 16'($urandom_range(1, lvl));
					frac = $urandom_range(0, 1500);
					ir = ((bb * frac) / 1024 > lvl) ? lvl[15:0]
						: 16'((bb * frac) / 1024);
				end
				offer_reading(bb, ir, 1'b0, '0);
			end
		end

		drain_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d reading pairs over %0d register settings, %0d results checked",
			readings_sent, settings_used, results_checked);
		$display("%0d saturated, long output hold of %0d cycles once", saturated_seen,
			HOLD_CYCLES);
		if (errors == 0) begin
			$display("ambient_light_lux_calc regression: pass");
		end else begin
			$display("ambient_light_lux_calc regression: fail");
		end
		$finish;
	end

	// result side: random stall per transaction, with one long hold on request
	initial begin : result_side
		int      n;
		lux_rd_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
			end else begin
				n = rush ? 0 : $urandom_range(0, 7);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
			if (lux_due.size() == 0) begin
				$error("unexpected result: lux %0d clipped %0b", lux, clipped);
				errors++;
			end else begin
				want = lux_due.pop_front();
				if (lux !== want.lux) begin
					$error("lux: expected %0d, got %0d", want.lux, lux);
					errors++;
				end
				if (clipped !== want.clipped) begin
					$error("clipped: expected %0b, got %0b", want.clipped, clipped);
					errors++;
				end
				if (want.clipped) saturated_seen++;
				results_checked++;
			end
		end
	end

	// watchdog: too long without a transaction on either side means a hang
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == STUCK_LIMIT) begin
			$display("timeout after %0d idle cycles, %0d results outstanding", STUCK_LIMIT,
				lux_due.size());
			$display("ambient_light_lux_calc regression: fail");
			$finish;
		end
	end

endmodule
